### sv/dscw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscw_pkg: shared types and constants of the sector chain walker
// Command, status, register and image kind codes, the result record and
// the zoned sector table of the single and double sided image formats.
// ----------------------------------------------------------------------------
package dscw_pkg;

	localparam int unsigned SIDE_TRACKS     = 40;
	localparam int unsigned SECTOR_PAYLOAD  = 254;
	localparam int unsigned SIDE_ONE_TRACKS = 35;
	localparam int unsigned FLAT_TRACKS     = 80;
	localparam int unsigned FLAT_SECTORS    = 40;
	localparam int unsigned LEN_W           = 20;
	localparam int unsigned BLK_W           = 12;
	localparam logic [2:0]  TYPE_PROGRAM    = 3'd2;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LINK  = 2'd1;
	localparam logic [1:0] CMD_FAIL  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOT_PRG = 2'd1;
	localparam logic [1:0] ST_TOO_BIG = 2'd2;

	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_DOUBLE = 2'd1;
	localparam logic [1:0] KIND_FLAT   = 2'd2;

	localparam logic CFG_IMAGE_KIND   = 1'b0;
	localparam logic CFG_BUFFER_BYTES = 1'b1;

	localparam logic [LEN_W-1:0] BUFFER_RESET = 20'd65536;

	typedef struct packed {
		logic             fetch_request;
		logic [LEN_W-1:0] fetch_offset;
		logic [7:0]       copy_bytes;
		logic             finished;
		logic [1:0]       status;
		logic [LEN_W-1:0] total_bytes;
	} result_t;

	// sectors of the zoned layout that lie before track n+1
	function automatic logic [9:0] zoned_before(input logic [5:0] n);
		logic [9:0] r;
		if (n <= 6'd17)
			r = 10'(21 * int'(n));
		else if (n <= 6'd24)
			r = 10'(357 + 19 * (int'(n) - 17));
		else if (n <= 6'd30)
			r = 10'(490 + 18 * (int'(n) - 24));
		else
			r = 10'(598 + 17 * (int'(n) - 30));
		return r;
	endfunction

endpackage

### sv/dscw_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscw_offset: track and sector to image byte offset
// Maps a track and sector to the byte offset of the sector in the image and
// flags tracks that lie outside the selected format.
// ----------------------------------------------------------------------------
module dscw_offset (
	input  logic [1:0]                 image_kind,
	input  logic [7:0]                 track_num,
	input  logic [7:0]                 sector_num,
	output logic                       track_ok,
	output logic [dscw_pkg::LEN_W-1:0] offset
);

	logic [7:0]                 side_track;
	logic [9:0]                 side_base;
	logic [7:0]                 prev_track;
	logic [dscw_pkg::BLK_W-1:0] blocks;
	logic                       second_side;

	assign second_side = (image_kind == dscw_pkg::KIND_DOUBLE)
		&& (track_num > 8'(dscw_pkg::SIDE_ONE_TRACKS));
	assign side_track  = second_side ? track_num - 8'(dscw_pkg::SIDE_ONE_TRACKS) : track_num;
	assign side_base   = second_side
		? dscw_pkg::zoned_before(6'(dscw_pkg::SIDE_ONE_TRACKS)) : 10'd0;
	assign prev_track  = (image_kind == dscw_pkg::KIND_FLAT) ? track_num - 8'd1
		: side_track - 8'd1;

	always_comb begin
		if (image_kind == dscw_pkg::KIND_FLAT) begin
			track_ok = (track_num != 8'd0) && (track_num <= 8'(dscw_pkg::FLAT_TRACKS));
			blocks   = BLK_W_cast(prev_track) * 12'(dscw_pkg::FLAT_SECTORS)
				+ {4'd0, sector_num};
		end else begin
			track_ok = (side_track != 8'd0) && (side_track <= 8'(dscw_pkg::SIDE_TRACKS));
			blocks   = {2'd0, side_base} + {2'd0, dscw_pkg::zoned_before(prev_track[5:0])}
				+ {4'd0, sector_num};
		end
	end

	assign offset = {blocks, 8'h00};

	function automatic logic [dscw_pkg::BLK_W-1:0] BLK_W_cast(input logic [7:0] v);
		return {4'd0, v};
	endfunction

endmodule

### sv/dscw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscw_core: chain state and result logic
// Holds the chain flag and the loaded length, forms the result of one item
// and advances the state when that item moves to the output register.
// ----------------------------------------------------------------------------
module dscw_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [1:0]                 image_kind,
	input  logic [dscw_pkg::LEN_W-1:0] buffer_bytes,
	input  logic [1:0]                 cmd,
	input  logic [7:0]                 track_num,
	input  logic [7:0]                 sector_num,
	input  logic [7:0]                 file_type,
	output dscw_pkg::result_t          result
);

	logic                       active_q;
	logic [dscw_pkg::LEN_W-1:0] length_q;
	logic                       active_d;
	logic [dscw_pkg::LEN_W-1:0] length_d;
	logic                       track_ok;
	logic [dscw_pkg::LEN_W-1:0] offset;
	logic [7:0]                 link_len;
	logic [dscw_pkg::LEN_W-1:0] sum_len;
	logic                       fits_start;
	logic                       fits_sum;

	dscw_offset u_offset (
		.image_kind (image_kind),
		.track_num  (track_num),
		.sector_num (sector_num),
		.track_ok   (track_ok),
		.offset     (offset)
	);

	assign link_len   = (track_num != 8'd0) ? 8'(dscw_pkg::SECTOR_PAYLOAD)
		: ((sector_num == 8'd0) ? 8'd0 : sector_num - 8'd1);
	assign sum_len    = length_q + {12'd0, link_len};
	assign fits_start = 21'(dscw_pkg::SECTOR_PAYLOAD) <= {1'b0, buffer_bytes};
	assign fits_sum   = ({1'b0, sum_len} + 21'(dscw_pkg::SECTOR_PAYLOAD))
		<= {1'b0, buffer_bytes};

	always_comb begin
		result   = '0;
		active_d = active_q;
		length_d = length_q;
		case (cmd)
			dscw_pkg::CMD_START: begin
				active_d = 1'b0;
				length_d = '0;
				if (file_type[2:0] != dscw_pkg::TYPE_PROGRAM || track_num == 8'd0) begin
					result.finished = 1'b1;
					result.status   = dscw_pkg::ST_NOT_PRG;
				end else if (!fits_start) begin
					result.finished = 1'b1;
					result.status   = dscw_pkg::ST_TOO_BIG;
				end else if (!track_ok) begin
					result.finished = 1'b1;
				end else begin
					result.fetch_request = 1'b1;
					result.fetch_offset  = offset;
					active_d             = 1'b1;
				end
			end
			dscw_pkg::CMD_FAIL: begin
				result.total_bytes = length_q;
				if (active_q) begin
					result.finished = 1'b1;
					active_d        = 1'b0;
				end
			end
			dscw_pkg::CMD_LINK: begin
				result.total_bytes = length_q;
				if (active_q) begin
					if (link_len == 8'd0) begin
						result.finished = 1'b1;
						active_d        = 1'b0;
					end else begin
						length_d           = sum_len;
						result.copy_bytes  = link_len;
						result.total_bytes = sum_len;
						if (!fits_sum) begin
							result.finished    = 1'b1;
							result.status      = dscw_pkg::ST_TOO_BIG;
							result.total_bytes = '0;
							active_d           = 1'b0;
						end else if (track_num == 8'd0 || !track_ok) begin
							result.finished = 1'b1;
							active_d        = 1'b0;
						end else begin
							result.fetch_request = 1'b1;
							result.fetch_offset  = offset;
						end
					end
				end
			end
			default: begin
				result.total_bytes = length_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			length_q <= '0;
		end else if (advance) begin
			active_q <= active_d;
			length_q <= length_d;
		end
	end

endmodule

### sv/disk_image_sector_chain_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_image_sector_chain_walker: file sector chain walker for disk images
// Follows the track and sector links of a program file and reports the image
// offset of every sector to fetch, the bytes to copy and the running length.
// ----------------------------------------------------------------------------
// Usage: write image_kind (index 0) and buffer_bytes (index 1) through the
// cfg_we / cfg_index / cfg_data port while no item is in flight. Send a start
// item (cmd 0) with the directory entry, then one link item (cmd 1) with the
// two link bytes of every sector fetched, or a fail item (cmd 2) when a fetch
// could not be done. Every input item gives exactly one result item.
// Both channels use valid/ready. An accepted item is held in the input
// register and its result is loaded into the output register once that
// register is empty or being read. One item is taken per cycle while the
// receiver keeps up; the rate is set by the single pass through the offset
// table, add and compare between the two registers.
// When the receiver stalls, the result holds and one more item can wait in
// the input register; in_ready drops only when both are full.
// Reset clears both valid flags, the chain state and the length, and sets
// the image kind to single sided and the buffer size to 65536 bytes.
// ----------------------------------------------------------------------------
module disk_image_sector_chain_walker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [dscw_pkg::LEN_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 cmd,
	input  logic [7:0]                 track_num,
	input  logic [7:0]                 sector_num,
	input  logic [7:0]                 file_type,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       fetch_request,
	output logic [dscw_pkg::LEN_W-1:0] fetch_offset,
	output logic [7:0]                 copy_bytes,
	output logic                       finished,
	output logic [1:0]                 status,
	output logic [dscw_pkg::LEN_W-1:0] total_bytes
);

	logic [1:0]                 image_kind_q;
	logic [dscw_pkg::LEN_W-1:0] buffer_bytes_q;
	logic                       valid_s1;
	logic [1:0]                 cmd_s1;
	logic [7:0]                 track_s1;
	logic [7:0]                 sector_s1;
	logic [7:0]                 type_s1;
	logic                       valid_s2;
	dscw_pkg::result_t          res_s2;
	dscw_pkg::result_t          result;
	logic                       advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	dscw_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.image_kind   (image_kind_q),
		.buffer_bytes (buffer_bytes_q),
		.cmd          (cmd_s1),
		.track_num    (track_s1),
		.sector_num   (sector_s1),
		.file_type    (type_s1),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_kind_q   <= dscw_pkg::KIND_SINGLE;
			buffer_bytes_q <= dscw_pkg::BUFFER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dscw_pkg::CFG_IMAGE_KIND:   image_kind_q   <= cfg_data[1:0];
				dscw_pkg::CFG_BUFFER_BYTES: buffer_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1    <= cmd;
			track_s1  <= track_num;
			sector_s1 <= sector_num;
			type_s1   <= file_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign fetch_request = res_s2.fetch_request;
	assign fetch_offset  = res_s2.fetch_offset;
	assign copy_bytes    = res_s2.copy_bytes;
	assign finished      = res_s2.finished;
	assign status        = res_s2.status;
	assign total_bytes   = res_s2.total_bytes;

endmodule

### test/tb_disk_image_sector_chain_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_image_sector_chain_walker: self-checking bench of the chain walker
// Sends start, link, fail and unused commands under every image kind and a
// range of buffer sizes, predicts each result from a local model of the
// walker state and compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module tb_disk_image_sector_chain_walker;

	typedef logic [dscw_pkg::LEN_W-1:0] len_t;

	localparam int CYCLE_LIMIT = 400000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	len_t       cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] cmd;
	logic [7:0] track_num;
	logic [7:0] sector_num;
	logic [7:0] file_type;
	logic       out_valid;
	logic       out_ready;
	logic       fetch_request;
	len_t       fetch_offset;
	logic [7:0] copy_bytes;
	logic       finished;
	logic [1:0] status;
	len_t       total_bytes;

	disk_image_sector_chain_walker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.track_num    (track_num),
		.sector_num   (sector_num),
		.file_type    (file_type),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fetch_request(fetch_request),
		.fetch_offset (fetch_offset),
		.copy_bytes   (copy_bytes),
		.finished     (finished),
		.status       (status),
		.total_bytes  (total_bytes)
	);

	logic [1:0] img_kind      = dscw_pkg::KIND_SINGLE;
	len_t       buf_limit     = dscw_pkg::BUFFER_RESET;
	bit         chain_live    = 1'b0;
	len_t       length_so_far = '0;

	dscw_pkg::result_t walker_results_due[$];

	int  mismatches    = 0;
	int  items_taken   = 0;
	int  useful_items  = 0;
	int  results_seen  = 0;
	int  ends_ok       = 0;
	int  ends_not_prg  = 0;
	int  ends_too_big  = 0;
	int  cycle_count   = 0;
	bit  feed_gaps     = 1'b0;
	bit  drain_stalls  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// sectors of the zoned layout on tracks 1 .. n
	function automatic int zoned_sectors_upto(int n);
		int total;
		total = 0;
		for (int t = 1; t <= n; t++)
			total += (t <= 17) ? 21 : (t <= 24) ? 19 : (t <= 30) ? 18 : 17;
		return total;
	endfunction

	function automatic bit locate_sector(input logic [7:0] trk, input logic [7:0] sec,
		output len_t off);
		int base;
		int side_trk;
		off = '0;
		if (img_kind == dscw_pkg::KIND_FLAT) begin
			if (trk == 0 || trk > dscw_pkg::FLAT_TRACKS)
				return 1'b0;
			off = len_t'(((int'(trk) - 1) * dscw_pkg::FLAT_SECTORS + int'(sec)) * 256);
			return 1'b1;
		end
		base = 0;
		side_trk = int'(trk);
		if (trk > dscw_pkg::SIDE_ONE_TRACKS && img_kind == dscw_pkg::KIND_DOUBLE) begin
			base = zoned_sectors_upto(dscw_pkg::SIDE_ONE_TRACKS);
			side_trk = int'(trk) - dscw_pkg::SIDE_ONE_TRACKS;
		end
		if (side_trk == 0 || side_trk > dscw_pkg::SIDE_TRACKS)
			return 1'b0;
		off = len_t'((base + zoned_sectors_upto(side_trk - 1) + int'(sec)) * 256);
		return 1'b1;
	endfunction

	function automatic bit room_for_sector();
		return (int'(length_so_far) + dscw_pkg::SECTOR_PAYLOAD) <= int'(buf_limit);
	endfunction

	function automatic dscw_pkg::result_t chain_end(logic [1:0] st);
		dscw_pkg::result_t r;
		r = '0;
		r.finished = 1'b1;
		r.status = st;
		r.total_bytes = (st == dscw_pkg::ST_OK) ? length_so_far : '0;
		chain_live = 1'b0;
		return r;
	endfunction

	function automatic dscw_pkg::result_t request_sector(logic [7:0] trk, logic [7:0] sec);
		dscw_pkg::result_t r;
		len_t off;
		if (!room_for_sector())
			return chain_end(dscw_pkg::ST_TOO_BIG);
		if (!locate_sector(trk, sec, off))
			return chain_end(dscw_pkg::ST_OK);
		r = '0;
		r.fetch_request = 1'b1;
		r.fetch_offset = off;
		r.total_bytes = length_so_far;
		chain_live = 1'b1;
		return r;
	endfunction

	function automatic dscw_pkg::result_t walk_chain(logic [1:0] c, logic [7:0] trk,
		logic [7:0] sec, logic [7:0] typ);
		dscw_pkg::result_t r;
		int len;
		r = '0;
		if (c == dscw_pkg::CMD_START) begin
			chain_live = 1'b0;
			length_so_far = '0;
			if (typ[2:0] != dscw_pkg::TYPE_PROGRAM || trk == 0)
				return chain_end(dscw_pkg::ST_NOT_PRG);
			return request_sector(trk, sec);
		end
		if (!chain_live || c == dscw_pkg::CMD_NONE) begin
			r.total_bytes = length_so_far;
			return r;
		end
		if (c == dscw_pkg::CMD_FAIL)
			return chain_end(dscw_pkg::ST_OK);
		len = (trk != 0) ? dscw_pkg::SECTOR_PAYLOAD : (sec == 0) ? 0 : int'(sec) - 1;
		if (len == 0)
			return chain_end(dscw_pkg::ST_OK);
		length_so_far = length_so_far + len_t'(len);
		if (trk == 0)
			r = chain_end(room_for_sector() ? dscw_pkg::ST_OK : dscw_pkg::ST_TOO_BIG);
		else
			r = request_sector(trk, sec);
		r.copy_bytes = 8'(len);
		return r;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		dscw_pkg::result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == dscw_pkg::CFG_IMAGE_KIND)
					img_kind = cfg_data[1:0];
				else
					buf_limit = cfg_data;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (walker_results_due.size() == 0) begin
					$error("result item arrived with nothing expected");
					mismatches++;
				end else begin
					want = walker_results_due.pop_front();
					compare_field("fetch_request", want.fetch_request, fetch_request);
					compare_field("fetch_offset", want.fetch_offset, fetch_offset);
					compare_field("copy_bytes", want.copy_bytes, copy_bytes);
					compare_field("finished", want.finished, finished);
					compare_field("status", want.status, status);
					compare_field("total_bytes", want.total_bytes, total_bytes);
				end
			end
			if (in_valid && in_ready) begin
				items_taken++;
				if (cmd == dscw_pkg::CMD_START || (cmd != dscw_pkg::CMD_NONE && chain_live))
					useful_items++;
				want = walk_chain(cmd, track_num, sector_num, file_type);
				if (want.finished) begin
					if (want.status == dscw_pkg::ST_OK)
						ends_ok++;
					else if (want.status == dscw_pkg::ST_NOT_PRG)
						ends_not_prg++;
					else
						ends_too_big++;
				end
				walker_results_due.push_back(want);
			end
		end
	end

	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (drain_stalls && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL disk_image_sector_chain_walker");
		$finish;
	end

	task automatic send_item(input logic [1:0] c, input logic [7:0] trk, input logic [7:0] sec,
		input logic [7:0] typ);
		if (feed_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		track_num <= trk;
		sector_num <= sec;
		file_type <= typ;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic drain_walker();
		in_valid <= 1'b0;
		@(posedge clk);
		while (walker_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_walker(input logic [1:0] kind, input len_t limit);
		drain_walker();
		cfg_we <= 1'b1;
		cfg_index <= dscw_pkg::CFG_IMAGE_KIND;
		cfg_data <= len_t'(kind);
		@(posedge clk);
		cfg_index <= dscw_pkg::CFG_BUFFER_BYTES;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] chain_track(logic [1:0] kind);
		int top;
		top = (kind == dscw_pkg::KIND_FLAT) ? dscw_pkg::FLAT_TRACKS :
			(kind == dscw_pkg::KIND_DOUBLE) ? dscw_pkg::SIDE_ONE_TRACKS + dscw_pkg::SIDE_TRACKS
			: dscw_pkg::SIDE_TRACKS;
		if ($urandom_range(0, 19) == 0)
			return 8'($urandom_range(top + 1, 255));
		return 8'($urandom_range(1, top));
	endfunction

	function automatic logic [7:0] chain_sector();
		return $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom_range(0, 255));
	endfunction

	task automatic test_idle_commands();
		send_item(dscw_pkg::CMD_LINK, 8'd18, 8'd1, 8'h00);
		send_item(dscw_pkg::CMD_FAIL, 8'hFF, 8'hFF, 8'hFF);
		send_item(dscw_pkg::CMD_NONE, 8'h00, 8'h00, 8'h82);
	endtask

	task automatic test_chain_cases();
		send_item(dscw_pkg::CMD_START, 8'd17, 8'd3, 8'h81);
		send_item(dscw_pkg::CMD_START, 8'd0, 8'd0, 8'h82);
		send_item(dscw_pkg::CMD_START, 8'd1, 8'd0, 8'h82);
		send_item(dscw_pkg::CMD_LINK, 8'd17, 8'd20, 8'h00);
		send_item(dscw_pkg::CMD_NONE, 8'd5, 8'd5, 8'h00);
		send_item(dscw_pkg::CMD_LINK, 8'd40, 8'd255, 8'h00);
		send_item(dscw_pkg::CMD_LINK, 8'd41, 8'd0, 8'h00);
		send_item(dscw_pkg::CMD_START, 8'd18, 8'd0, 8'hFA);
		send_item(dscw_pkg::CMD_START, 8'd25, 8'd7, 8'h02);
		send_item(dscw_pkg::CMD_LINK, 8'd0, 8'd255, 8'h00);
		send_item(dscw_pkg::CMD_START, 8'd30, 8'd1, 8'h82);
		send_item(dscw_pkg::CMD_FAIL, 8'd0, 8'd0, 8'h00);
		send_item(dscw_pkg::CMD_START, 8'd31, 8'd2, 8'h82);
		send_item(dscw_pkg::CMD_LINK, 8'd0, 8'd0, 8'h00);
		send_item(dscw_pkg::CMD_START, 8'd255, 8'd0, 8'h82);
	endtask

	task automatic test_image_kinds();
		program_walker(dscw_pkg::KIND_DOUBLE, dscw_pkg::BUFFER_RESET);
		send_item(dscw_pkg::CMD_START, 8'd35, 8'd0, 8'h82);
		send_item(dscw_pkg::CMD_LINK, 8'd36, 8'd0, 8'h00);
		send_item(dscw_pkg::CMD_LINK, 8'd75, 8'd255, 8'h00);
		send_item(dscw_pkg::CMD_LINK, 8'd76, 8'd0, 8'h00);
		program_walker(dscw_pkg::KIND_FLAT, dscw_pkg::BUFFER_RESET);
		send_item(dscw_pkg::CMD_START, 8'd80, 8'd39, 8'h82);
		send_item(dscw_pkg::CMD_LINK, 8'd81, 8'd0, 8'h00);
		program_walker(2'd3, dscw_pkg::BUFFER_RESET);
		send_item(dscw_pkg::CMD_START, 8'd40, 8'd0, 8'h82);
	endtask

	task automatic test_buffer_edges();
		program_walker(dscw_pkg::KIND_SINGLE, '0);
		send_item(dscw_pkg::CMD_START, 8'd1, 8'd0, 8'h82);
		program_walker(dscw_pkg::KIND_SINGLE, len_t'(dscw_pkg::SECTOR_PAYLOAD));
		send_item(dscw_pkg::CMD_START, 8'd1, 8'd0, 8'h82);
		send_item(dscw_pkg::CMD_LINK, 8'd2, 8'd0, 8'h00);
		send_item(dscw_pkg::CMD_START, 8'd1, 8'd0, 8'h82);
		send_item(dscw_pkg::CMD_LINK, 8'd0, 8'd255, 8'h00);
		program_walker(dscw_pkg::KIND_SINGLE, '1);
		send_item(dscw_pkg::CMD_START, 8'd1, 8'd0, 8'h82);
	endtask

	task automatic test_random_chains();
		logic [1:0] kind;
		len_t       limit;
		int         goal;
		int         links;
		for (int phase = 0; phase < 8; phase++) begin
			kind = 2'(phase % 4);
			case ($urandom_range(0, 4))
				0: limit = dscw_pkg::BUFFER_RESET;
				1: limit = len_t'($urandom_range(0, 3000));
				2: limit = len_t'(dscw_pkg::SECTOR_PAYLOAD * $urandom_range(0, 12));
				3: limit = '1;
				default: limit = len_t'($urandom_range(0, 20'hFFFFF));
			endcase
			program_walker(kind, limit);
			feed_gaps = (phase != 7);
			drain_stalls = (phase != 7);
			goal = items_taken + 215;
			while (items_taken < goal) begin
				if ($urandom_range(0, 99) < 15) begin
					send_item(2'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()),
						8'($urandom()));
				end else begin
					send_item(dscw_pkg::CMD_START, chain_track(kind), chain_sector(),
						($urandom_range(0, 9) == 0) ? 8'($urandom()) :
						{5'($urandom()), dscw_pkg::TYPE_PROGRAM});
					links = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) :
						$urandom_range(1, 12);
					for (int k = 0; k < links; k++)
						send_item(dscw_pkg::CMD_LINK, chain_track(kind), chain_sector(),
							8'($urandom()));
					case ($urandom_range(0, 9))
						0: send_item(dscw_pkg::CMD_FAIL, 8'($urandom()), 8'($urandom()),
							8'($urandom()));
						1: ;
						default: send_item(dscw_pkg::CMD_LINK, 8'd0, 8'($urandom_range(0, 255)),
							8'($urandom()));
					endcase
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= dscw_pkg::CFG_IMAGE_KIND;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= dscw_pkg::CMD_START;
		track_num <= '0;
		sector_num <= '0;
		file_type <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_commands();
		test_chain_cases();
		test_image_kinds();
		test_buffer_edges();
		test_random_chains();
		drain_walker();

		$display("walked %0d items (%0d acting on a chain), checked %0d results",
			items_taken, useful_items, results_seen);
		$display("chain endings: %0d normal, %0d not a program, %0d over buffer",
			ends_ok, ends_not_prg, ends_too_big);
		if (mismatches == 0 && walker_results_due.size() == 0)
			$display("PASS disk_image_sector_chain_walker");
		else
			$display("FAIL disk_image_sector_chain_walker");
		$finish;
	end

endmodule
